[src/assert_macros.svh]
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: always");
// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/deq_pkg.sv]
// Types and constants of the double-ended queue.
`default_nettype none
package deq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // one-cycle command broadcast to every cell
    typedef struct packed {
        logic add_front;
        logic add_back;
        logic take_front;
        logic take_back;
    } t_cell_ctl;

endpackage
`default_nettype wire

[src/deq_if.sv]
// Request and result channel interfaces of the double-ended queue.
`default_nettype none
interface deq_req_if
    import deq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    t_req                       req_type;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface deq_rsp_if
    import deq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  pop_value;
    t_status                    status;
    logic [COUNT_W-1:0]         item_count;

    modport source (output valid, output pop_value, output status, output item_count,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input item_count,
                    output ready);
endinterface
`default_nettype wire

[src/deq_cell.sv]
// One storage cell of the queue chain: a value and its occupied flag.
`default_nettype none
module deq_cell
    import deq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_left_valid,
    input  wire logic [VALUE_W-1:0] i_left_data,
    input  wire logic               i_right_valid,
    input  wire logic [VALUE_W-1:0] i_right_data,
    output logic                    o_valid,
    output logic [VALUE_W-1:0]      o_data,
    output logic                    o_last
);

    logic               r_valid;
    logic [VALUE_W-1:0] r_data;
    logic               n_valid;
    logic [VALUE_W-1:0] n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.add_front) begin
            // shift toward the back
            n_valid = i_left_valid;
            n_data  = i_left_data;
        end else if (i_ctl.add_back) begin
            // first free cell takes the value
            if (!r_valid && i_left_valid) begin
                n_valid = 1'b1;
                n_data  = i_value;
            end
        end else if (i_ctl.take_front) begin
            // shift toward the front
            n_valid = i_right_valid;
            n_data  = i_right_data;
        end else if (i_ctl.take_back) begin
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_valid && !i_right_valid;

endmodule
`default_nettype wire

[src/double_ended_queue.sv]
// Top level of the double-ended queue: a chain of storage cells and a result register.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------
//  i_req    | in  | valid / ready    | req_type, value
//  o_rsp    | out | valid / ready    | pop_value, status, item_count
//
// One item per cycle while results are taken: each request is resolved in the
// cycle it is accepted and its result lands in the output register on the next
// edge. The cell chain is the queue state; a dropped push or empty pop moves no cell.
// Reset (synchronous, active low) clears the occupied flags, the count and the
// output valid; cell values stay undefined until pushed.
// A stalled result holds the register and blocks new requests until taken.
`default_nettype none
`include "assert_macros.svh"
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    deq_req_if.sink     i_req,
    deq_rsp_if.source   o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    // cell chain wires; front value lives in cell 0, values packed toward it
    logic [DEPTH-1:0]   w_valid;
    logic [VALUE_W-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]   w_last;
    t_cell_ctl          w_ctl;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_pop_value;
    logic [VALUE_W-1:0] n_pop_value;
    t_status            r_status;
    t_status            n_status;
    logic [COUNT_W-1:0] r_item_count;
    logic [CW+COUNT_W-1:0] w_count_ext;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_is_push;
    logic [VALUE_W-1:0] w_back_data;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_is_push   = (i_req.req_type == REQ_PUSH_FRONT) ||
                         (i_req.req_type == REQ_PUSH_BACK);

    // value held by the back cell, picked by its one-hot last flag
    always_comb begin
        w_back_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back_data = w_back_data | (w_data[k] & {VALUE_W{w_last[k]}});
        end
    end

    // decode request; dropped pushes and empty pops leave the cells alone
    always_comb begin
        w_ctl       = '0;
        n_count     = r_count;
        n_pop_value = '0;
        n_status    = ST_DONE;
        case (i_req.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.add_front = w_accept && (i_req.req_type == REQ_PUSH_FRONT);
                    w_ctl.add_back  = w_accept && (i_req.req_type == REQ_PUSH_BACK);
                    n_count         = r_count + CW'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.take_front = w_accept;
                    n_pop_value      = w_data[0];
                    n_count          = r_count - CW'(1);
                end
            end
            REQ_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.take_back = w_accept;
                    n_pop_value     = w_back_data;
                    n_count         = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // reported count is the low five bits
    assign w_count_ext = {{COUNT_W{1'b0}}, n_count};

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic               w_lv;
            logic [VALUE_W-1:0] w_ld;
            logic               w_rv;
            logic [VALUE_W-1:0] w_rd;

            if (g == 0) begin : g_head
                // ahead of the front: an always-full slot carrying the new value
                assign w_lv = 1'b1;
                assign w_ld = i_req.value;
            end else begin : g_mid_l
                assign w_lv = w_valid[g-1];
                assign w_ld = w_data[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_rv = 1'b0;
                assign w_rd = '0;
            end else begin : g_mid_r
                assign w_rv = w_valid[g+1];
                assign w_rd = w_data[g+1];
            end

            deq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_value       (i_req.value),
                .i_left_valid  (w_lv),
                .i_left_data   (w_ld),
                .i_right_valid (w_rv),
                .i_right_data  (w_rd),
                .o_valid       (w_valid[g]),
                .o_data        (w_data[g]),
                .o_last        (w_last[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_value  <= n_pop_value;
            r_status     <= n_status;
            r_item_count <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.pop_value  = r_pop_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.item_count = r_item_count;

    // occupied flags agree with the counter
    `ASSERT_ALWAYS(a_count_matches_cells, i_clk, i_rst_n, $countones(w_valid) == int'(r_count))
    // the front cell is occupied whenever the queue is not empty
    `ASSERT_ALWAYS(a_front_occupied, i_clk, i_rst_n, (r_count == '0) || w_valid[0])
    // a push into a full queue reports full and leaves the count alone
    `ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, w_accept && w_is_push && w_full, o_rsp.valid && (o_rsp.status == ST_FULL) && (r_count == CW'(DEPTH)))

endmodule
`default_nettype wire

[dv/tb_double_ended_queue.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the double-ended queue: scoreboard against a behavioral deque.
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int IDLE_LIMIT   = 1000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 8;     // result register is one stage deep

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        t_value             pop_value;
        t_status            status;
        logic [COUNT_W-1:0] item_count;
    } t_deq_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Behavioral deque: ring of DEPTH slots, head points at the front value,
    // tail one past the back value.
    t_value      ring_slots [DEPTH];
    int unsigned head_pos   = 0;
    int unsigned tail_pos   = 0;
    int unsigned fill_level = 0;

    t_deq_result expected_results [$];
    int          err_count    = 0;
    int          result_count = 0;
    int          idle_cycles  = 0;
    int          burst_left   = 0;

    logic [7:0]  stall_pattern = 8'hFF;
    int          pattern_age   = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Applies one request to the behavioral deque and returns its result.
    function automatic t_deq_result deque_step(input t_req kind, input t_value data);
        t_deq_result r;
        r.pop_value = '0;
        r.status    = ST_DONE;
        case (kind)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (kind == REQ_PUSH_FRONT) begin
                    head_pos = (head_pos == 0) ? DEPTH - 1 : head_pos - 1;
                    ring_slots[head_pos] = data;
                    fill_level++;
                end else begin
                    ring_slots[tail_pos] = data;
                    tail_pos = (tail_pos + 1) % DEPTH;
                    fill_level++;
                end
            end
            default: begin
                if (fill_level == 0) begin
                    r.status = ST_EMPTY;
                end else if (kind == REQ_POP_FRONT) begin
                    r.pop_value = ring_slots[head_pos];
                    head_pos = (head_pos + 1) % DEPTH;
                    fill_level--;
                end else begin
                    tail_pos = (tail_pos == 0) ? DEPTH - 1 : tail_pos - 1;
                    r.pop_value = ring_slots[tail_pos];
                    fill_level--;
                end
            end
        endcase
        r.item_count = COUNT_W'(fill_level);
        return r;
    endfunction

    // Sends one request; the sender runs in bursts with random gaps between.
    // Valid stays high from one item to the next inside a burst.
    task automatic send_req(input t_req kind, input t_value data);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value    <= data;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // Receiver stalls follow a rotating 8-bit pattern that changes now and then.
    // Bit 0 of a fresh pattern is always set, so every stall ends within one turn of it.
    always @(negedge i_clk) begin
        if (pattern_age == 0) begin
            pattern_age = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0:       stall_pattern = 8'hFF;
                1:       stall_pattern = 8'($urandom) | 8'h01;
                default: stall_pattern = 8'($urandom & $urandom) | 8'h01;
            endcase
        end
        pattern_age--;
        rsp_ch.ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
    end

    // Scoreboard and watchdog. Results are checked before the request of the
    // same edge is predicted; a result never comes in the cycle of its request.
    always @(posedge i_clk) begin
        t_deq_result want;
        if (i_rst_n) begin
            idle_cycles++;
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                idle_cycles = 0;
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request waiting",
                                              result_count));
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_ch.pop_value !== want.pop_value ||
                        rsp_ch.status !== want.status ||
                        rsp_ch.item_count !== want.item_count) begin
                        report_mismatch($sformatf(
                            "result %0d: pop_value %0d/%0d status %0d/%0d count %0d/%0d",
                            result_count, rsp_ch.pop_value, want.pop_value,
                            rsp_ch.status, want.status,
                            rsp_ch.item_count, want.item_count));
                    end
                end
            end
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
                idle_cycles = 0;
                expected_results.insert(expected_results.size(),
                                        deque_step(req_ch.req_type, req_ch.value));
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Pops on an empty queue, with a nonzero value that must be ignored.
    task automatic test_empty_pops();
        send_req(REQ_POP_FRONT, 32'sh7FFF_FFFF);
        send_req(REQ_POP_BACK, -1);
    endtask

    // Value extremes at both ends, then drained from both ends into empty.
    task automatic test_value_extremes();
        send_req(REQ_PUSH_BACK, 32'sh8000_0000);
        send_req(REQ_PUSH_BACK, 32'sh7FFF_FFFF);
        send_req(REQ_PUSH_FRONT, '0);
        send_req(REQ_PUSH_FRONT, -1);
        send_req(REQ_PUSH_BACK, 32'sh5555_5555);
        send_req(REQ_PUSH_FRONT, 32'shAAAA_AAAA);
        send_req(REQ_POP_FRONT, 32'sh1234_5678);
        send_req(REQ_POP_BACK, '0);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_POP_BACK, '0);
        send_req(REQ_POP_BACK, '0);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_POP_FRONT, '0);
    endtask

    // Fill past full (pushes dropped), then drain past empty, at random ends.
    task automatic test_full_and_wrap(input int rounds);
        for (int r = 0; r < rounds; r++) begin
            for (int i = 0; i < DEPTH + 2; i++)
                send_req(t_req'($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT),
                         $urandom);
            for (int i = 0; i < DEPTH + 2; i++)
                send_req(t_req'($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT),
                         $urandom);
        end
    endtask

    // Random traffic in phases: push-heavy phases run into full, pop-heavy
    // ones into empty, balanced ones wander and wrap the indices.
    task automatic test_random_traffic(input int num_items);
        int     phase_left;
        int     push_pct;
        t_req   kind;
        t_value data;
        phase_left = 0;
        push_pct   = 50;
        for (int i = 0; i < num_items; i++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            phase_left--;
            if ($urandom_range(0, 99) < push_pct)
                kind = t_req'($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT);
            else
                kind = t_req'($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT);
            case ($urandom_range(0, 15))
                0:       data = 32'sh8000_0000;
                1:       data = 32'sh7FFF_FFFF;
                2:       data = $urandom_range(0, 3) - 2;
                default: data = $urandom;
            endcase
            send_req(kind, data);
        end
    endtask

    initial begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_PUSH_FRONT;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pops();
        test_value_extremes();
        test_full_and_wrap(2);
        test_random_traffic(470);

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never came", expected_results.size()));

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/deq_pkg.sv
src/deq_if.sv
src/deq_cell.sv
src/double_ended_queue.sv
dv/tb_double_ended_queue.sv
